@@ hdl/hep_pkg.sv @@
// Types, register indexes, reset values and command codes for the Heston path stepper.
package hep_pkg;

   typedef struct packed {
      logic signed [31:0] dw_variance;
      logic signed [31:0] dw_price;
   } req_type;

   typedef struct packed {
      logic [31:0] price;
      logic [31:0] variance;
      logic [15:0] step_index;
      logic        last_of_path;
      logic        above_strike;
      logic [15:0] paths_done;
      logic [15:0] paths_above;
   } rsp_type;

   localparam int CsrIndexBits = 3;

   localparam logic [CsrIndexBits-1:0] CSR_MU_DT          = 3'd0;
   localparam logic [CsrIndexBits-1:0] CSR_KAPPA_DT       = 3'd1;
   localparam logic [CsrIndexBits-1:0] CSR_LONG_TERM_VAR  = 3'd2;
   localparam logic [CsrIndexBits-1:0] CSR_VOL_OF_VOL     = 3'd3;
   localparam logic [CsrIndexBits-1:0] CSR_INITIAL_VAR    = 3'd4;
   localparam logic [CsrIndexBits-1:0] CSR_INITIAL_PRICE  = 3'd5;
   localparam logic [CsrIndexBits-1:0] CSR_STRIKE         = 3'd6;
   localparam logic [CsrIndexBits-1:0] CSR_STEPS_PER_PATH = 3'd7;

   localparam logic signed [31:0] MU_DT_RESET          = 32'sd26844;
   localparam logic signed [31:0] KAPPA_DT_RESET       = 32'sd805306;
   localparam logic [30:0]        LONG_TERM_VAR_RESET  = 31'd40265318;
   localparam logic [30:0]        VOL_OF_VOL_RESET     = 31'd26843546;
   localparam logic [31:0]        INITIAL_VAR_RESET    = 32'd26843546;
   localparam logic [31:0]        INITIAL_PRICE_RESET  = 32'd6553600;
   localparam logic [31:0]        STRIKE_RESET         = 32'd7208960;
   localparam logic [15:0]        STEPS_PER_PATH_RESET = 16'd1000;

   // one root bit per iteration: sqrt of a 60-bit radicand
   localparam int SqrtSteps = 30;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_KAPPA,
      MUL_SIGMA,
      MUL_SG_DW1,
      MUL_S_DW2,
      MUL_P_LO,
      MUL_P_HI
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_NONE,
      ACC_VAR,
      ACC_FACTOR,
      ACC_PLO,
      ACC_PHI
   } acc_sel_type;

   typedef struct packed {
      logic        load;
      logic        sqrt_step;
      mul_sel_type mul_sel;
      acc_sel_type acc_sel;
      logic        finish;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQRT,
      ST_CALC,
      ST_FINISH
   } state_type;

endpackage

@@ hdl/heston_euler_path_step.sv @@
// Top level of the Heston Euler-Maruyama path stepper.
//
//   channel   direction  handshake               payload
//   req_      in         req_valid / req_ready   req_item  (dw_variance, dw_price)
//   rsp_      out        rsp_valid / rsp_ready   rsp_item  (price, variance, step, counts)
//   csr_      in         csr_we                  csr_index, csr_wdata
//
// An item is loaded at its accepting edge, then takes 30 square-root iterations,
// the calculation phases on the shared 33x32 multiplier and a finish step that updates
// the path state and the output register; no new item is accepted until that finish
// step is done.
// Reset is synchronous and restores the register defaults and the path state.
// The next item is accepted while a result waits; a step stalls in its last
// cycle only if the previous result has not been taken yet.
module heston_euler_path_step #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  hep_pkg::req_type                 req_item,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output hep_pkg::rsp_type                 rsp_item,
   input  logic                             csr_we,
   input  logic [hep_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [31:0]                      csr_wdata
);
   import hep_pkg::*;

   cmd_type cmd;

   hep_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   hep_datapath #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_item  (rsp_item)
   );

endmodule

@@ hdl/hep_ctrl.sv @@
// Sequencer for the Heston path stepper: handshakes and datapath commands.
module hep_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hep_pkg::cmd_type cmd
);
   import hep_pkg::*;

   localparam logic [4:0] SQRT_LAST = 5'(SqrtSteps - 1);

   localparam logic [4:0] PH_KAPPA  = 5'd0;
   localparam logic [4:0] PH_SIGMA  = 5'd1;
   localparam logic [4:0] PH_SG_DW1 = 5'd2;
   localparam logic [4:0] PH_S_DW2  = 5'd3;
   localparam logic [4:0] PH_FACTOR = 5'd4;
   localparam logic [4:0] PH_P_LO   = 5'd5;
   localparam logic [4:0] PH_P_HI   = 5'd6;
   localparam logic [4:0] PH_PHI    = 5'd7;

   state_type  state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      cmd           = '0;
      cmd.mul_sel   = MUL_NONE;
      cmd.acc_sel   = ACC_NONE;
      req_ready     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (cnt_ff == SQRT_LAST) begin
               cnt_in   = '0;
               state_in = ST_CALC;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         ST_CALC: begin
            cnt_in = cnt_ff + 5'd1;
            case (cnt_ff)
               PH_KAPPA:  cmd.mul_sel = MUL_KAPPA;
               PH_SIGMA: begin
                  cmd.mul_sel = MUL_SIGMA;
                  cmd.acc_sel = ACC_VAR;
               end
               PH_SG_DW1: cmd.mul_sel = MUL_SG_DW1;
               PH_S_DW2: begin
                  cmd.mul_sel = MUL_S_DW2;
                  cmd.acc_sel = ACC_VAR;
               end
               PH_FACTOR: cmd.acc_sel = ACC_FACTOR;
               PH_P_LO:   cmd.mul_sel = MUL_P_LO;
               PH_P_HI: begin
                  cmd.mul_sel = MUL_P_HI;
                  cmd.acc_sel = ACC_PLO;
               end
               PH_PHI: begin
                  cmd.acc_sel = ACC_PHI;
                  cnt_in      = '0;
                  state_in    = ST_FINISH;
               end
               default: begin
                  cnt_in   = '0;
                  state_in = ST_FINISH;
               end
            endcase
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ hdl/hep_datapath.sv @@
// Datapath: registers, path state, bit-serial square root and shared multiplier.
module hep_datapath #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  hep_pkg::cmd_type                   cmd,
   input  hep_pkg::req_type                   req_item,
   input  logic                               csr_we,
   input  logic [hep_pkg::CsrIndexBits-1:0]   csr_index,
   input  logic [31:0]                        csr_wdata,
   output hep_pkg::rsp_type                   rsp_item
);
   import hep_pkg::*;

   localparam logic [39:0] U32_MAX_40 = 40'h00_FFFF_FFFF;

   // configuration
   logic signed [31:0] mu_dt_ff, kappa_dt_ff;
   logic [30:0]        theta_ff, sigma_ff;
   logic [31:0]        init_var_ff, init_price_ff, strike_ff;
   logic [15:0]        steps_ff;

   // path state
   logic [31:0]             cur_price_ff, cur_price_in;
   logic [31:0]             cur_var_ff, cur_var_in;
   logic [15:0]             step_ff, step_in;
   logic [COUNTER_BITS-1:0] done_ff, done_in;
   logic [COUNTER_BITS-1:0] above_ff, above_in;

   // work registers
   logic signed [31:0] dw1_ff, dw2_ff;
   logic [59:0]        rad_ff;
   logic [32:0]        rem_ff, rem_in;
   logic [29:0]        root_ff, root_in;
   logic [64:0]        prod_ff, prod_in;
   logic               neg_ff;
   logic signed [39:0] vacc_ff;
   logic signed [35:0] factor_ff;
   logic [39:0]        pacc_ff;
   rsp_type            rsp_ff, rsp_in;

   // operand preparation
   logic signed [32:0] diff;
   logic [32:0]        diff_neg;
   logic [31:0]        diff_mag, kappa_mag, dw1_mag, dw2_mag;
   logic [32:0]        mul_a;
   logic [31:0]        mul_b;
   logic               mul_neg;
   logic [36:0]        prod_q;
   logic signed [39:0] prod_sq;

   // square root step
   logic [32:0] rem_sh, trial;

   // step result
   logic        factor_pos;
   logic [16:0] idx;
   logic        last;
   logic        above;
   logic [31:0] new_p, new_v;
   logic [31:0] done_ext, above_ext;

   assign diff      = $signed({2'b00, theta_ff}) - $signed({1'b0, cur_var_ff});
   assign diff_neg  = 33'(-diff);
   assign diff_mag  = diff[32] ? diff_neg[31:0] : diff[31:0];
   assign kappa_mag = kappa_dt_ff[31] ? 32'(-kappa_dt_ff) : kappa_dt_ff;
   assign dw1_mag   = dw1_ff[31] ? 32'(-dw1_ff) : dw1_ff;
   assign dw2_mag   = dw2_ff[31] ? 32'(-dw2_ff) : dw2_ff;

   assign factor_pos = ~factor_ff[35] && (factor_ff != 36'sd0);

   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_neg = 1'b0;
      case (cmd.mul_sel)
         MUL_KAPPA: begin
            mul_a   = {1'b0, diff_mag};
            mul_b   = kappa_mag;
            mul_neg = diff[32] ^ kappa_dt_ff[31];
         end
         MUL_SIGMA: begin
            mul_a = {3'b000, root_ff};
            mul_b = {1'b0, sigma_ff};
         end
         MUL_SG_DW1: begin
            mul_a   = prod_ff[60:28];
            mul_b   = dw1_mag;
            mul_neg = dw1_ff[31];
         end
         MUL_S_DW2: begin
            mul_a   = {3'b000, root_ff};
            mul_b   = dw2_mag;
            mul_neg = dw2_ff[31];
         end
         MUL_P_LO: begin
            mul_a = {5'b0, factor_ff[27:0]};
            mul_b = cur_price_ff;
         end
         MUL_P_HI: begin
            mul_a = {27'b0, factor_ff[33:28]};
            mul_b = cur_price_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      prod_in = 65'(mul_a) * 65'(mul_b);
   end

   assign prod_q  = prod_ff[64:28];
   assign prod_sq = neg_ff ? -$signed({3'b000, prod_q}) : $signed({3'b000, prod_q});

   // restoring square root, two radicand bits per root bit
   assign rem_sh = {rem_ff[30:0], rad_ff[59:58]};
   assign trial  = {1'b0, root_ff, 2'b01};

   always_comb begin
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_ff[28:0], 1'b1};
      end else begin
         rem_in  = rem_sh;
         root_in = {root_ff[28:0], 1'b0};
      end
   end

   // end of step
   always_comb begin
      idx   = {1'b0, step_ff} + 17'd1;
      last  = idx >= {1'b0, steps_ff};

      if (vacc_ff < 40'sd0)
         new_v = '0;
      else if (vacc_ff > $signed(U32_MAX_40))
         new_v = '1;
      else
         new_v = vacc_ff[31:0];

      if (!factor_pos)
         new_p = '0;
      else if (pacc_ff > U32_MAX_40)
         new_p = '1;
      else
         new_p = pacc_ff[31:0];

      above = last && (new_p > strike_ff);

      done_in  = last ? done_ff + COUNTER_BITS'(1) : done_ff;
      above_in = above ? above_ff + COUNTER_BITS'(1) : above_ff;

      if (last) begin
         cur_price_in = init_price_ff;
         cur_var_in   = init_var_ff;
         step_in      = '0;
      end else begin
         cur_price_in = new_p;
         cur_var_in   = new_v;
         step_in      = idx[15:0];
      end

      done_ext  = 32'(done_in);
      above_ext = 32'(above_in);

      rsp_in.price        = new_p;
      rsp_in.variance     = new_v;
      rsp_in.step_index   = idx[15:0];
      rsp_in.last_of_path = last;
      rsp_in.above_strike = above;
      rsp_in.paths_done   = done_ext[15:0];
      rsp_in.paths_above  = above_ext[15:0];
   end

   // configuration and path state
   always_ff @(posedge clock) begin
      if (reset) begin
         mu_dt_ff      <= MU_DT_RESET;
         kappa_dt_ff   <= KAPPA_DT_RESET;
         theta_ff      <= LONG_TERM_VAR_RESET;
         sigma_ff      <= VOL_OF_VOL_RESET;
         init_var_ff   <= INITIAL_VAR_RESET;
         init_price_ff <= INITIAL_PRICE_RESET;
         strike_ff     <= STRIKE_RESET;
         steps_ff      <= STEPS_PER_PATH_RESET;
         cur_price_ff  <= INITIAL_PRICE_RESET;
         cur_var_ff    <= INITIAL_VAR_RESET;
         step_ff       <= '0;
         done_ff       <= '0;
         above_ff      <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MU_DT:          mu_dt_ff      <= csr_wdata;
               CSR_KAPPA_DT:       kappa_dt_ff   <= csr_wdata;
               CSR_LONG_TERM_VAR:  theta_ff      <= csr_wdata[30:0];
               CSR_VOL_OF_VOL:     sigma_ff      <= csr_wdata[30:0];
               CSR_INITIAL_VAR:    init_var_ff   <= csr_wdata;
               CSR_INITIAL_PRICE:  init_price_ff <= csr_wdata;
               CSR_STRIKE:         strike_ff     <= csr_wdata;
               CSR_STEPS_PER_PATH: steps_ff      <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (cmd.finish) begin
            cur_price_ff <= cur_price_in;
            cur_var_ff   <= cur_var_in;
            step_ff      <= step_in;
            done_ff      <= done_in;
            above_ff     <= above_in;
         end
      end
   end

   // work registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dw1_ff    <= req_item.dw_variance;
         dw2_ff    <= req_item.dw_price;
         rad_ff    <= {cur_var_ff, 28'b0};
         rem_ff    <= '0;
         root_ff   <= '0;
         vacc_ff   <= $signed({8'b0, cur_var_ff});
         factor_ff <= 36'sd268435456 + 36'(mu_dt_ff);
      end
      if (cmd.sqrt_step) begin
         rad_ff  <= {rad_ff[57:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= prod_in;
         neg_ff  <= mul_neg;
      end
      case (cmd.acc_sel)
         ACC_VAR:    vacc_ff   <= vacc_ff + prod_sq;
         ACC_FACTOR: factor_ff <= factor_ff + prod_sq[35:0];
         ACC_PLO:    pacc_ff   <= {3'b000, prod_q};
         ACC_PHI:    pacc_ff   <= pacc_ff + prod_ff[39:0];
         default: ;
      endcase
      if (cmd.finish)
         rsp_ff <= rsp_in;
   end

   assign rsp_item = rsp_ff;

endmodule

@@ tb/sv/hep_step_checker.sv @@
// Step checker for the Heston path stepper: tracks path state, predicts each step, compares.
module hep_step_checker #(
   parameter int COUNTER_BITS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   input  logic                             req_ready,
   input  hep_pkg::req_type                 req_item,
   input  logic                             rsp_valid,
   input  logic                             rsp_ready,
   input  hep_pkg::rsp_type                 rsp_item,
   input  logic                             csr_we,
   input  logic [hep_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [31:0]                      csr_wdata,
   output int                               error_count,
   output int                               steps_in_flight
);
   import hep_pkg::*;

   localparam int     FracBits = 28;
   localparam longint WordMax  = 64'h0000_0000_FFFF_FFFF;

   // register copies
   logic signed [31:0] mu_dt, kappa_dt;
   logic [30:0]        theta, sigma;
   logic [31:0]        init_var, init_price, strike;
   logic [15:0]        steps_per_path;

   // path state
   logic [31:0]             price, variance;
   logic [15:0]             step_count;
   logic [COUNTER_BITS-1:0] done_count, above_count;

   rsp_type expected_steps[$];

   function automatic longint isqrt_q28(logic [31:0] v);
      longint unsigned radicand, root, trial;
      radicand = {32'b0, v};
      radicand = radicand << FracBits;
      root = 0;
      for (int b = 29; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= radicand) root = trial;
      end
      return longint'(root);
   endfunction

   // Q4.28 product, truncated toward zero
   function automatic longint mul_q28(longint a, longint b);
      longint unsigned ma, mb, prod;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      prod = (ma * mb) >> FracBits;
      return ((a < 0) != (b < 0)) ? -longint'(prod) : longint'(prod);
   endfunction

   function automatic logic [31:0] sat_word(longint x);
      if (x < 0) return '0;
      if (x > WordMax) return '1;
      return x[31:0];
   endfunction

   function automatic rsp_type predict_step(req_type it);
      longint  dw1, dw2, v, root, sg, new_var, factor, hi, lo, new_price;
      int      idx;
      bit      last;
      rsp_type res;
      dw1 = longint'(signed'(it.dw_variance));
      dw2 = longint'(signed'(it.dw_price));
      v = longint'(variance);
      root = isqrt_q28(variance);
      sg = (longint'(sigma) * root) >> FracBits;
      new_var = v + mul_q28(longint'(theta) - v, longint'(kappa_dt)) + mul_q28(sg, dw1);
      factor = (longint'(1) << FracBits) + longint'(mu_dt) + mul_q28(root, dw2);
      if (factor <= 0) begin
         new_price = 0;
      end else begin
         hi = factor >> FracBits;
         lo = factor & ((longint'(1) << FracBits) - 1);
         new_price = longint'(price) * hi + ((longint'(price) * lo) >> FracBits);
      end
      idx = int'(step_count) + 1;
      last = idx >= int'(steps_per_path);
      res.price = sat_word(new_price);
      res.variance = sat_word(new_var);
      res.step_index = 16'(idx);
      res.last_of_path = last;
      res.above_strike = last && (res.price > strike);
      if (last) begin
         done_count++;
         if (res.above_strike) above_count++;
         price = init_price;
         variance = init_var;
         step_count = '0;
      end else begin
         price = res.price;
         variance = res.variance;
         step_count = 16'(idx);
      end
      res.paths_done = done_count;
      res.paths_above = above_count;
      return res;
   endfunction

   task automatic check_field(string field, longint unsigned want, longint unsigned got);
      if (want != got) begin
         error_count++;
         if (error_count <= 10)
            $display("mismatch in %s: expected %0h, got %0h", field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         mu_dt = MU_DT_RESET;
         kappa_dt = KAPPA_DT_RESET;
         theta = LONG_TERM_VAR_RESET;
         sigma = VOL_OF_VOL_RESET;
         init_var = INITIAL_VAR_RESET;
         init_price = INITIAL_PRICE_RESET;
         strike = STRIKE_RESET;
         steps_per_path = STEPS_PER_PATH_RESET;
         price = INITIAL_PRICE_RESET;
         variance = INITIAL_VAR_RESET;
         step_count = '0;
         done_count = '0;
         above_count = '0;
         expected_steps.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_MU_DT:          mu_dt = csr_wdata;
               CSR_KAPPA_DT:       kappa_dt = csr_wdata;
               CSR_LONG_TERM_VAR:  theta = csr_wdata[30:0];
               CSR_VOL_OF_VOL:     sigma = csr_wdata[30:0];
               CSR_INITIAL_VAR:    init_var = csr_wdata;
               CSR_INITIAL_PRICE:  init_price = csr_wdata;
               CSR_STRIKE:         strike = csr_wdata;
               CSR_STEPS_PER_PATH: steps_per_path = csr_wdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_steps.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("result with no step pending: price %0h, step %0d",
                           rsp_item.price, rsp_item.step_index);
            end else begin
               want = expected_steps.pop_front();
               check_field("price", want.price, rsp_item.price);
               check_field("variance", want.variance, rsp_item.variance);
               check_field("step_index", want.step_index, rsp_item.step_index);
               check_field("last_of_path", want.last_of_path, rsp_item.last_of_path);
               check_field("above_strike", want.above_strike, rsp_item.above_strike);
               check_field("paths_done", want.paths_done, rsp_item.paths_done);
               check_field("paths_above", want.paths_above, rsp_item.paths_above);
            end
         end
         if (req_valid && req_ready)
            expected_steps.insert(expected_steps.size(), predict_step(req_item));
      end
      steps_in_flight = expected_steps.size();
   end

endmodule

@@ tb/sv/tb.sv @@
// Testbench top for the Heston path stepper: drives steps and register writes, gives the verdict.
module tb;
   import hep_pkg::*;

   localparam int Latency    = 40;
   localparam int PhaseItems = 120;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   req_type                 req_item = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   rsp_type                 rsp_item;
   logic                    csr_we = 1'b0;
   logic [CsrIndexBits-1:0] csr_index = '0;
   logic [31:0]             csr_wdata = '0;
   int                      error_count;
   int                      steps_in_flight;
   logic                    gaps_on = 1'b1;
   int                      hold_asks = 0;
   int                      holds_done = 0;

   heston_euler_path_step DUT (
      .clock, .reset,
      .req_valid, .req_ready, .req_item,
      .rsp_valid, .rsp_ready, .rsp_item,
      .csr_we, .csr_index, .csr_wdata
   );

   hep_step_checker step_check (
      .clock, .reset,
      .req_valid, .req_ready, .req_item,
      .rsp_valid, .rsp_ready, .rsp_item,
      .csr_we, .csr_index, .csr_wdata,
      .error_count, .steps_in_flight
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asks != holds_done) begin
            holds_done = hold_asks;
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end
         rsp_ready <= !gaps_on || ($urandom_range(99) >= 17);
      end
   end

   task automatic send_step(input logic [31:0] dwv, input logic [31:0] dwp);
      if (gaps_on && $urandom_range(99) < 17) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 60)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= '{dw_variance: dwv, dw_price: dwp};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (steps_in_flight != 0);
      repeat (Latency + 10) @(posedge clock);
   endtask

   task automatic program_regs(input logic [31:0] mu, kappa, theta, sigma,
                               input logic [31:0] ivar, iprice, strk, steps);
      logic [31:0] vals [8];
      vals[CSR_MU_DT] = mu;
      vals[CSR_KAPPA_DT] = kappa;
      vals[CSR_LONG_TERM_VAR] = theta;
      vals[CSR_VOL_OF_VOL] = sigma;
      vals[CSR_INITIAL_VAR] = ivar;
      vals[CSR_INITIAL_PRICE] = iprice;
      vals[CSR_STRIKE] = strk;
      vals[CSR_STEPS_PER_PATH] = steps;
      for (int i = 0; i < 8; i++) begin
         csr_we <= 1'b1;
         csr_index <= CsrIndexBits'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] draw_increment();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 10) begin
         case ($urandom_range(3))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (pick < 30) return $urandom();
      return $urandom_range(0, 1 << 27) - (1 << 26);
   endfunction

   initial begin
      int unsigned price0, steps;
      bit          wild;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // register defaults: extremes of both increments, negative variance, zero price
      send_step(32'h0000_0000, 32'h0000_0000);
      send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_step(32'h8000_0000, 32'h8000_0000);
      send_step(32'h7FFF_FFFF, 32'h8000_0000);
      send_step(32'h8000_0000, 32'h7FFF_FFFF);
      send_step(32'h0000_0001, 32'hFFFF_FFFF);
      send_step(32'hFFFF_FFFF, 32'h0000_0001);
      drain();

      // new start price mid-path, then path length lowered below the current step
      program_regs(MU_DT_RESET, KAPPA_DT_RESET, LONG_TERM_VAR_RESET, VOL_OF_VOL_RESET,
                   INITIAL_VAR_RESET, 32'h0100_0000, STRIKE_RESET, 10);
      send_step(32'h0100_0000, 32'h0100_0000);
      send_step(32'hFF00_0000, 32'h0080_0000);
      drain();
      program_regs(MU_DT_RESET, KAPPA_DT_RESET, LONG_TERM_VAR_RESET, VOL_OF_VOL_RESET,
                   INITIAL_VAR_RESET, 32'h0100_0000, STRIKE_RESET, 5);
      send_step(32'h0000_0000, 32'h0100_0000);
      send_step(32'h0000_0000, 32'h0000_0000);
      drain();

      // saturation of variance and price, zero path length
      program_regs(32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0);
      send_step(32'h7FFF_FFFF, 32'h0000_0000);
      send_step(32'h8000_0000, 32'h7FFF_FFFF);
      send_step(32'h0000_0000, 32'h8000_0000);
      send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      drain();

      // all registers at their minimum, but the strike at its maximum and a path length of 1
      program_regs(32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0,
                   32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1);
      send_step(32'h0000_0000, 32'h0000_0000);
      send_step(32'h7FFF_FFFF, 32'h8000_0000);
      drain();

      // strongest mean reversion from zero variance
      program_regs(32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1000_0000,
                   32'h0, INITIAL_PRICE_RESET, INITIAL_PRICE_RESET, 3);
      send_step(32'h8000_0000, 32'h8000_0000);
      send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_step(32'h0000_0000, 32'h0000_0000);
      send_step(32'h8000_0000, 32'h0000_0000);
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         wild = (ph == 2 || ph == 7);
         gaps_on <= (ph != 3);
         if (ph == 4) steps = 65535;
         else if (ph == 8) steps = 1;
         else steps = $urandom_range(0, 30);
         if (wild) begin
            program_regs($urandom(), $urandom(), $urandom(), $urandom(),
                         $urandom(), $urandom(), $urandom(), steps);
         end else begin
            price0 = $urandom_range(1 << 20, 1 << 24);
            program_regs($urandom_range(0, 1 << 21) - (1 << 20), $urandom_range(0, 1 << 25),
                         $urandom_range(0, 1 << 28), $urandom_range(0, 1 << 29),
                         $urandom_range(0, 1 << 28), price0,
                         price0 + $urandom_range(0, 1 << 20) - (1 << 19), steps);
         end
         for (int n = 0; n < PhaseItems; n++) begin
            if (ph == 6 && n == 30) hold_asks <= hold_asks + 1;
            send_step(draw_increment(), draw_increment());
         end
         drain();
      end

      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
